// ===== hdl/fatlb_pkg.sv =====
// shared types and codes for the fully associative tlb
package fatlb_pkg;

    localparam int unsigned DEF_ENTRIES = 16;
    localparam int unsigned PAGE_W      = 8;
    localparam int unsigned FRAME_W     = 16;
    localparam int unsigned FUNC_W      = 3;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOOKUP  = 3'd0,
        FUNC_INSERT  = 3'd1,
        FUNC_PROBE   = 3'd2,
        FUNC_REPLACE = 3'd3,
        FUNC_FLUSH   = 3'd4
    } t_func;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
        logic [PAGE_W-1:0]  old_page;
        logic [FRAME_W-1:0] old_frame;
    } t_req;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame_out;
        logic               victim_valid;
        logic [PAGE_W-1:0]  victim_page;
        logic [FRAME_W-1:0] victim_frame;
    } t_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } t_state;

    typedef struct packed {
        logic load_req;
        logic capture;
        logic update;
    } t_cmd;

endpackage

// ===== hdl/fatlb_ctrl.sv =====
// request sequencing and output handshake control for the tlb
module fatlb_ctrl
    import fatlb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   upd_go;
    logic   in_acc;

    assign upd_go     = (r_state == ST_UPD) && (!r_out_valid || !i_out_stall);
    assign o_in_stall = !((r_state == ST_IDLE) || upd_go);
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) n_state = ST_CMP;
            end
            ST_CMP: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                if (upd_go) n_state = in_acc ? ST_CMP : ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.load_req = in_acc;
        o_cmd.capture  = (r_state == ST_CMP);
        o_cmd.update   = upd_go;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (upd_go) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== hdl/fatlb_dpath.sv =====
// tlb entry storage, parallel compare, priority select and update
module fatlb_dpath
    import fatlb_pkg::*;
#(
    parameter int unsigned ENTRIES = DEF_ENTRIES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  t_req i_req,
    output t_rsp o_rsp
);

    localparam int unsigned IDX_W = $clog2(ENTRIES);

    t_req               r_req;
    logic [ENTRIES-1:0] r_valid;
    logic [PAGE_W-1:0]  r_page  [ENTRIES];
    logic [FRAME_W-1:0] r_frame [ENTRIES];
    logic [IDX_W-1:0]   r_ptr;
    logic [ENTRIES-1:0] r_pm, r_xm, r_free;
    t_rsp               r_rsp;

    logic [PAGE_W-1:0]  key_page;
    logic [FRAME_W-1:0] key_frame;
    logic [IDX_W-1:0]   pm_idx, xm_idx, free_idx, vic_idx, wr_idx;
    logic               wr_en, flush, ptr_en;
    logic [IDX_W-1:0]   n_ptr;
    t_rsp               n_rsp;

    // compare keys: replace matches on the old pair
    always_comb begin
        key_page  = i_req.page;
        key_frame = i_req.frame;
        if (r_req.func == FUNC_REPLACE) begin
            key_page  = r_req.old_page;
            key_frame = r_req.old_frame;
        end else begin
            key_page  = r_req.page;
            key_frame = r_req.frame;
        end
    end

    always_comb begin
        pm_idx   = '0;
        xm_idx   = '0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_pm[i])   pm_idx   = IDX_W'(i);
            if (r_xm[i])   xm_idx   = IDX_W'(i);
            if (r_free[i]) free_idx = IDX_W'(i);
        end
    end

    assign vic_idx = (r_ptr == IDX_W'(ENTRIES - 1)) ? '0 : r_ptr + 1'b1;

    always_comb begin
        n_rsp  = '0;
        wr_en  = 1'b0;
        wr_idx = free_idx;
        flush  = 1'b0;
        ptr_en = 1'b0;
        n_ptr  = r_ptr;
        case (r_req.func)
            FUNC_LOOKUP: begin
                if (|r_pm) begin
                    n_rsp.hit       = 1'b1;
                    n_rsp.frame_out = r_frame[pm_idx];
                    ptr_en          = 1'b1;
                    n_ptr           = pm_idx;
                end
            end
            FUNC_INSERT: begin
                wr_en = 1'b1;
                if (|r_free) begin
                    wr_idx = free_idx;
                end else begin
                    wr_idx             = vic_idx;
                    n_rsp.victim_valid = 1'b1;
                    n_rsp.victim_page  = r_page[vic_idx];
                    n_rsp.victim_frame = r_frame[vic_idx];
                    ptr_en             = 1'b1;
                    n_ptr              = vic_idx;
                end
            end
            FUNC_PROBE: begin
                n_rsp.hit = |r_xm;
            end
            FUNC_REPLACE: begin
                if (|r_xm) begin
                    n_rsp.hit = 1'b1;
                    wr_en     = 1'b1;
                    wr_idx    = xm_idx;
                    ptr_en    = 1'b1;
                    n_ptr     = xm_idx;
                end
            end
            FUNC_FLUSH: begin
                flush = 1'b1;
            end
            default: begin
                n_rsp = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) r_req <= i_req;
        if (i_cmd.capture) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_pm[i]   <= r_valid[i] && (r_page[i] == key_page);
                r_xm[i]   <= r_valid[i] && (r_page[i] == key_page)
                             && (r_frame[i] == key_frame);
                r_free[i] <= !r_valid[i];
            end
        end
        if (i_cmd.update) begin
            r_rsp <= n_rsp;
            if (wr_en) begin
                r_page[wr_idx]  <= r_req.page;
                r_frame[wr_idx] <= r_req.frame;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ptr   <= '0;
        end else if (i_cmd.update) begin
            if (flush) begin
                r_valid <= '0;
            end else if (wr_en) begin
                r_valid[wr_idx] <= 1'b1;
            end
            if (ptr_en) r_ptr <= n_ptr;
        end
    end

    assign o_rsp = r_rsp;

endmodule

// ===== hdl/fully_assoc_tlb_round_robin_unit.sv =====
// top level of the fully associative tlb with round-robin replacement
//
// usage
//   request channel: i_in_valid / o_in_stall carry one request (func, page,
//   frame, old_page, old_frame). a request is taken at a rising edge where
//   i_in_valid is high and o_in_stall is low.
//   response channel: o_out_valid / i_out_stall carry one response per
//   request (hit, frame_out, victim_valid, victim_page, victim_frame).
//   steps: the compare state compares every entry in parallel and
//   registers the match vectors, then the update state priority-selects,
//   updates the entries and the pointer and loads the output register.
//   the next request is taken in the update state, while the previous
//   request finishes; during compare o_in_stall is high.
//   stall: while a response waits under i_out_stall, the pending update
//   holds, o_in_stall is high outside idle and nothing is lost or repeated.
//   reset: all entries invalid, replacement pointer zero, no response
//   pending.
module fully_assoc_tlb_round_robin_unit
    import fatlb_pkg::*;
#(
    parameter int unsigned ENTRIES = DEF_ENTRIES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_req,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out_rsp
);

    t_cmd cmd;

    fatlb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    fatlb_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_in_req),
        .o_rsp   (o_out_rsp)
    );

    a_accept_then_compare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> cmd.capture)
        else $error("request taken without a compare cycle");

    a_compare_then_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.capture && !(o_out_valid && i_out_stall)) |=> cmd.update)
        else $error("compare not followed by update with output free");

    a_update_gives_response: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.update |=> o_out_valid)
        else $error("update did not present a response");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.capture && cmd.update))
        else $error("compare and update in the same cycle");

endmodule
